// ===== design/idm_pkg.sv =====
// shared types for the pipelined integer divider
`default_nettype none

package idm_pkg;

   // sign fixups carried alongside each operation
   typedef struct packed {
      logic neg_quo;
      logic neg_rem;
   } sign_flags_type;

   // operand and result port width
   localparam int unsigned PORT_WIDTH = 64;

endpackage

`default_nettype wire

// ===== design/idm_prep.sv =====
// input stage: operand truncation and magnitude conversion for signed mode
`default_nettype none

module idm_prep #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic                         in_signed,
   input  wire logic [idm_pkg::PORT_WIDTH-1:0] in_dividend,
   input  wire logic [idm_pkg::PORT_WIDTH-1:0] in_divisor,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [DATA_WIDTH-1:0]             out_num,
   output logic [DATA_WIDTH-1:0]             out_den,
   output idm_pkg::sign_flags_type           out_flags
);
   import idm_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH-1:0] den_in;
   sign_flags_type        flags_ff;
   sign_flags_type        flags_in;
   logic [DATA_WIDTH-1:0] num_raw;
   logic [DATA_WIDTH-1:0] den_raw;
   logic                  num_neg;
   logic                  den_neg;

   // slot is free when empty or draining this cycle
   assign in_ready = !valid_ff || out_ready;

   // magnitudes and sign fixups
   always_comb begin
      num_raw = in_dividend[DATA_WIDTH-1:0];
      den_raw = in_divisor[DATA_WIDTH-1:0];
      num_neg = in_signed && num_raw[DATA_WIDTH-1];
      den_neg = in_signed && den_raw[DATA_WIDTH-1];
      num_in = num_neg ? (~num_raw + 1'b1) : num_raw;
      den_in = den_neg ? (~den_raw + 1'b1) : den_raw;
      flags_in.neg_quo = num_neg ^ den_neg;
      flags_in.neg_rem = num_neg;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

`default_nettype wire

// ===== design/idm_step.sv =====
// one restoring division step with its pipeline register
`default_nettype none

module idm_step #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_part,
   input  wire logic [DATA_WIDTH-1:0] in_acc,
   input  wire logic [DATA_WIDTH-1:0] in_den,
   input  wire idm_pkg::sign_flags_type in_flags,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [DATA_WIDTH-1:0]   out_part,
   output logic [DATA_WIDTH-1:0]   out_acc,
   output logic [DATA_WIDTH-1:0]   out_den,
   output idm_pkg::sign_flags_type out_flags
);
   import idm_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] part_ff;
   logic [DATA_WIDTH-1:0] part_in;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] acc_in;
   logic [DATA_WIDTH-1:0] den_ff;
   sign_flags_type        flags_ff;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;

   assign in_ready = !valid_ff || out_ready;

   // shift in the next dividend bit, trial subtract, keep or restore;
   // the accumulator holds remaining dividend bits above and quotient bits below
   always_comb begin
      shifted  = {in_part[DATA_WIDTH-2:0], in_acc[DATA_WIDTH-1]};
      diff     = {1'b0, shifted} - {1'b0, in_den};
      take     = !diff[DATA_WIDTH];
      part_in  = take ? diff[DATA_WIDTH-1:0] : shifted;
      acc_in   = {in_acc[DATA_WIDTH-2:0], take};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         part_ff  <= part_in;
         acc_ff   <= acc_in;
         den_ff   <= in_den;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_part  = part_ff;
   assign out_acc   = acc_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

`default_nettype wire

// ===== design/idm_post.sv =====
// output stage: sign fixup of quotient and remainder into the result register
`default_nettype none

module idm_post #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_quo,
   input  wire logic [DATA_WIDTH-1:0] in_rem,
   input  wire idm_pkg::sign_flags_type in_flags,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output logic [idm_pkg::PORT_WIDTH-1:0] out_quotient,
   output logic [idm_pkg::PORT_WIDTH-1:0] out_remainder
);
   import idm_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] quo_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;

   assign in_ready = !valid_ff || !out_stall;

   // conditional negation, wrapping
   always_comb begin
      quo_in   = in_flags.neg_quo ? (~in_quo + 1'b1) : in_quo;
      rem_in   = in_flags.neg_rem ? (~in_rem + 1'b1) : in_rem;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // bits above the operand width read as zero
   assign out_valid     = valid_ff;
   assign out_quotient  = PORT_WIDTH'(quo_ff);
   assign out_remainder = PORT_WIDTH'(rem_ff);

endmodule

`default_nettype wire

// ===== design/int64_divide_modulo.sv =====
// pipelined signed/unsigned integer divider giving quotient and remainder
// a transfer passes the prep, step and result registers before the result is valid
// throughput: one transfer per cycle unless rsp_stall holds it; one restoring step
//   per stage, a single (DATA_WIDTH+1)-bit subtract and select between registers
// a stalled result holds only the stages behind it that are full; empty slots fill
// reset clears every stage valid bit; the pipeline is empty afterwards
`default_nettype none

module int64_divide_modulo #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [idm_pkg::PORT_WIDTH-1:0] req_dividend,
   input  wire logic [idm_pkg::PORT_WIDTH-1:0] req_divisor,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [idm_pkg::PORT_WIDTH-1:0]      rsp_quotient,
   output logic [idm_pkg::PORT_WIDTH-1:0]      rsp_remainder
);
   import idm_pkg::*;

   logic                  req_ready;
   logic                  stage_valid [0:DATA_WIDTH];
   logic                  stage_ready [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stage_part  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stage_acc   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stage_den   [0:DATA_WIDTH];
   sign_flags_type        stage_flags [0:DATA_WIDTH];

   assign req_stall = !req_ready;

   // operand preparation
   idm_prep #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_signed  (req_type),
      .in_dividend(req_dividend),
      .in_divisor (req_divisor),
      .out_valid  (stage_valid[0]),
      .out_ready  (stage_ready[0]),
      .out_num    (stage_acc[0]),
      .out_den    (stage_den[0]),
      .out_flags  (stage_flags[0])
   );

   // partial remainder starts at zero
   assign stage_part[0] = '0;

   // one stage per quotient bit
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      idm_step #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .in_valid (stage_valid[i]),
         .in_ready (stage_ready[i]),
         .in_part  (stage_part[i]),
         .in_acc   (stage_acc[i]),
         .in_den   (stage_den[i]),
         .in_flags (stage_flags[i]),
         .out_valid(stage_valid[i+1]),
         .out_ready(stage_ready[i+1]),
         .out_part (stage_part[i+1]),
         .out_acc  (stage_acc[i+1]),
         .out_den  (stage_den[i+1]),
         .out_flags(stage_flags[i+1])
      );
   end

   // sign fixup and result register
   idm_post #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid[DATA_WIDTH]),
      .in_ready     (stage_ready[DATA_WIDTH]),
      .in_quo       (stage_acc[DATA_WIDTH]),
      .in_rem       (stage_part[DATA_WIDTH]),
      .in_flags     (stage_flags[DATA_WIDTH]),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_quotient (rsp_quotient),
      .out_remainder(rsp_remainder)
   );

   // unsigned remainder is below a nonzero divisor after the last step
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DATA_WIDTH] && (stage_den[DATA_WIDTH] != '0)
      |-> stage_part[DATA_WIDTH] < stage_den[DATA_WIDTH])
      else $error("remainder not below divisor at last step");

   // zero divisor yields an all-ones unsigned quotient
   a_zero_den_quo: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DATA_WIDTH] && (stage_den[DATA_WIDTH] == '0)
      |-> stage_acc[DATA_WIDTH] == '1)
      else $error("zero divisor did not give all-ones quotient");

   // a held last step keeps its valid and data while the result stage is full
   a_last_step_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DATA_WIDTH] && !stage_ready[DATA_WIDTH]
      |=> stage_valid[DATA_WIDTH] && $stable(stage_acc[DATA_WIDTH])
          && $stable(stage_part[DATA_WIDTH]))
      else $error("last division step lost data while held");

   // result stage frees its slot whenever the result is taken
   a_post_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> stage_ready[DATA_WIDTH])
      else $error("result stage not ready while free");

endmodule

`default_nettype wire
